>>> design/ppt_pkg.sv
// Shared types, constants and single-precision arithmetic steps for the
// projective point transform pipeline. No dependencies.
package ppt_pkg;

    localparam logic [31:0] QNAN = 32'h7FC00000;
    localparam logic [31:0] INF  = 32'h7F800000;

    localparam int NSTG      = 44;
    localparam int DIV_STEPS = 28;
    localparam int SIDE_N    = DIV_STEPS + 2;

    localparam logic [2:0] CFG_X_GAINS    = 3'd0;
    localparam logic [2:0] CFG_Y_GAINS    = 3'd1;
    localparam logic [2:0] CFG_W_GAINS    = 3'd2;
    localparam logic [2:0] CFG_XY_OFFSETS = 3'd3;
    localparam logic [2:0] CFG_W_OFFSET   = 3'd4;
    localparam logic [2:0] CFG_W_EPSILON  = 3'd5;

    // unpacked operand, subnormals pre-normalized (e may drop below 1)
    typedef struct packed {
        logic              s;
        logic signed [10:0] e;
        logic [23:0]       m;
        logic              nan;
        logic              inf;
        logic              zero;
    } t_unp;

    typedef struct packed {
        logic              s;
        logic signed [10:0] e;
        logic [47:0]       p;
        logic              nan;
        logic              inf;
        logic              zero;
    } t_mulp;

    // unrounded value: sig[25:2] mantissa, sig[1] guard, sig[0] sticky
    typedef struct packed {
        logic              s;
        logic signed [10:0] e;
        logic [25:0]       sig;
        logic              nan;
        logic              inf;
        logic              zero;
    } t_rnd;

    typedef struct packed {
        logic              s;
        logic              zs;
        logic signed [10:0] e;
        logic              sub;
        logic [26:0]       ma;
        logic [26:0]       mb;
        logic              nan;
        logic              inf;
    } t_alig;

    typedef struct packed {
        logic              s;
        logic              zs;
        logic signed [10:0] e;
        logic [27:0]       sum;
        logic [4:0]        lz;
        logic              nan;
        logic              inf;
    } t_sum;

    // reciprocal in progress; flags describe the result 1/W
    typedef struct packed {
        logic              s;
        logic signed [10:0] e;
        logic [24:0]       rem;
        logic [23:0]       d;
        logic [27:0]       q;
        logic              nan;
        logic              inf;
        logic              zero;
    } t_div;

    typedef struct packed {
        logic        degen;
        logic [31:0] fx;
        logic [31:0] fy;
    } t_side;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        n = 5'd28;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) n = 5'(27 - i);
        end
        return n;
    endfunction

    function automatic t_unp f_unpack(input logic [31:0] f);
        t_unp       u;
        logic [4:0] lz;
        lz     = lzc24({1'b0, f[22:0]});
        u.s    = f[31];
        u.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
        u.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
        u.zero = (f[30:0] == 31'd0);
        if (f[30:23] != 8'd0) begin
            u.m = {1'b1, f[22:0]};
            u.e = $signed({3'b000, f[30:23]});
        end else begin
            u.m = {1'b0, f[22:0]} << lz;
            u.e = 11'sd1 - $signed({6'b000000, lz});
        end
        return u;
    endfunction

    function automatic logic [31:0] round_pack(input t_rnd r);
        logic [25:0]        sig;
        logic signed [10:0] e;
        logic [10:0]        sh;
        logic [25:0]        msk;
        logic               inc;
        logic [24:0]        mr;
        logic [35:0]        w;
        logic [31:0]        res;
        sig = r.sig;
        e   = r.e;
        if (e < 11'sd1) begin
            sh = 11'(11'sd1 - e);
            if (sh > 11'd25) begin
                sig = {25'd0, |r.sig};
            end else begin
                msk = (26'd1 << sh) - 26'd1;
                sig = (r.sig >> sh) | {25'd0, |(r.sig & msk)};
            end
            e = 11'sd1;
        end
        inc = sig[1] & (sig[0] | sig[2]);
        mr  = {1'b0, sig[25:2]} + {24'd0, inc};
        w   = ({25'd0, 11'(e - 11'sd1)} << 23) + {11'd0, mr};
        if (r.nan) begin
            res = QNAN;
        end else if (r.inf) begin
            res = {r.s, INF[30:0]};
        end else if (r.zero) begin
            res = {r.s, 31'd0};
        end else if (w >= {4'd0, INF}) begin
            res = {r.s, INF[30:0]};
        end else begin
            res = {r.s, w[30:0]};
        end
        return res;
    endfunction

    function automatic t_mulp mul_a(input t_unp a, input t_unp b);
        t_mulp r;
        r.s    = a.s ^ b.s;
        r.nan  = a.nan | b.nan | (a.inf & b.zero) | (a.zero & b.inf);
        r.inf  = a.inf | b.inf;
        r.zero = a.zero | b.zero;
        r.e    = a.e + b.e - 11'sd127;
        r.p    = {24'd0, a.m} * {24'd0, b.m};
        return r;
    endfunction

    function automatic t_rnd mul_b(input t_mulp m);
        t_rnd r;
        r.s    = m.s;
        r.nan  = m.nan;
        r.inf  = m.inf & ~m.nan;
        r.zero = m.zero & ~m.nan;
        if (m.p[47]) begin
            r.sig = {m.p[47:23], |m.p[22:0]};
            r.e   = m.e + 11'sd1;
        end else begin
            r.sig = {m.p[46:22], |m.p[21:0]};
            r.e   = m.e;
        end
        return r;
    endfunction

    function automatic t_alig add_a(input logic [31:0] a, input logic [31:0] b);
        t_alig       r;
        logic [31:0] bg;
        logic [31:0] sm;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [26:0] xs;
        logic [26:0] msk;
        logic        an;
        logic        bn;
        logic        ai;
        logic        bi;
        if (a[30:0] >= b[30:0]) begin
            bg = a;
            sm = b;
        end else begin
            bg = b;
            sm = a;
        end
        eb = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
        es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
        d  = eb - es;
        xs = {sm[30:23] != 8'd0, sm[22:0], 3'b000};
        if (d > 8'd26) begin
            r.mb = {26'd0, |xs};
        end else begin
            msk  = (27'd1 << d) - 27'd1;
            r.mb = (xs >> d) | {26'd0, |(xs & msk)};
        end
        an    = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        bn    = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ai    = (a[30:0] == INF[30:0]);
        bi    = (b[30:0] == INF[30:0]);
        r.ma  = {bg[30:23] != 8'd0, bg[22:0], 3'b000};
        r.s   = bg[31];
        r.zs  = a[31] & b[31];
        r.sub = a[31] ^ b[31];
        r.e   = $signed({3'b000, eb});
        r.nan = an | bn | (ai & bi & r.sub);
        r.inf = ai | bi;
        return r;
    endfunction

    function automatic t_sum add_b(input t_alig a);
        t_sum r;
        r.s   = a.s;
        r.zs  = a.zs;
        r.e   = a.e;
        r.nan = a.nan;
        r.inf = a.inf;
        r.sum = a.sub ? ({1'b0, a.ma} - {1'b0, a.mb}) : ({1'b0, a.ma} + {1'b0, a.mb});
        r.lz  = lzc28(r.sum);
        return r;
    endfunction

    function automatic t_rnd add_c(input t_sum a);
        t_rnd        r;
        logic [27:0] t;
        t      = a.sum << a.lz;
        r.e    = a.e + 11'sd1 - $signed({6'b000000, a.lz});
        r.sig  = {t[27:4], t[3], |t[2:0]};
        r.nan  = a.nan;
        r.inf  = a.inf & ~a.nan;
        r.zero = (a.sum == 28'd0) & ~a.nan & ~a.inf;
        r.s    = r.zero ? a.zs : a.s;
        return r;
    endfunction

    function automatic t_div div_init(input logic [31:0] w);
        t_div r;
        t_unp u;
        u      = f_unpack(w);
        r.s    = u.s;
        r.nan  = u.nan;
        r.inf  = u.zero;
        r.zero = u.inf;
        r.e    = 11'sd253 - u.e;
        r.rem  = 25'h0800000;
        r.d    = u.m;
        r.q    = 28'd0;
        return r;
    endfunction

    function automatic t_div div_step(input t_div a);
        t_div        r;
        logic        ge;
        logic [24:0] nr;
        r     = a;
        ge    = (a.rem >= {1'b0, a.d});
        nr    = ge ? (a.rem - {1'b0, a.d}) : a.rem;
        r.q   = {a.q[26:0], ge};
        r.rem = {nr[23:0], 1'b0};
        return r;
    endfunction

    function automatic t_rnd div_fin(input t_div a);
        t_rnd r;
        r.s    = a.s;
        r.nan  = a.nan;
        r.inf  = a.inf & ~a.nan;
        r.zero = a.zero & ~a.nan;
        if (a.q[27]) begin
            r.sig = {1'b1, 25'd0};
            r.e   = a.e + 11'sd1;
        end else begin
            r.sig = {a.q[26:3], a.q[2], (|a.q[1:0]) | (a.rem != 25'd0)};
            r.e   = a.e;
        end
        return r;
    endfunction

    function automatic logic is_degen(input logic [31:0] w, input logic [31:0] eps);
        return (w[30:0] <= INF[30:0]) && (eps[30:0] <= INF[30:0]) && !eps[31]
            && (w[30:0] < eps[30:0]);
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] v);
        return (v[30:0] > INF[30:0]) ? QNAN : v;
    endfunction

endpackage

>>> design/ppt_ifs.sv
// Stream channel interfaces for the projective point transform.
// Point beats in and transformed point beats out; no dependencies.
interface ppt_pt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_in;
    logic [31:0] y_in;
    logic        last_in;
    modport source (output valid, x_in, y_in, last_in, input ready);
    modport sink   (input valid, x_in, y_in, last_in, output ready);
endinterface

interface ppt_pt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic        w_degenerate;
    logic        last_out;
    modport source (output valid, x_out, y_out, w_degenerate, last_out, input ready);
    modport sink   (input valid, x_out, y_out, w_degenerate, last_out, output ready);
endinterface

>>> design/projective_point_transform.sv
// Projective point transform top level: 3x3 homography on float points.
// Depends on ppt_pkg and the channel interfaces in ppt_ifs.sv.
//
// Usage: points enter on i_pt (x_in, y_in as float bits, last_in) and leave
// on o_pt (x_out, y_out, w_degenerate, last_out). A beat moves when valid
// and ready are both high. The matrix is set through the write port
// (i_cfg_we, i_cfg_idx, i_cfg_data); the user must do so only while no point
// is in flight; the block does not enforce it. One point per cycle while
// o_pt takes beats. Multiplies run mul_a, mul_b and rounding, adds run
// add_a, add_b, add_c and rounding; a 28-stage divider, one bit per stage, gives 1/W.
// Reset: synchronous; all stages are emptied, the matrix returns to the
// identity with epsilon 1e-6, and i_pt.ready stays low through reset.
// Stall: when the result beat is not taken and the last stage is full, the
// whole pipeline holds and i_pt.ready drops; bubbles are not squeezed out.
// Degenerate W (|W| below epsilon) gives quiet NaN on both outputs.
module projective_point_transform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ppt_pt_in_if.sink           i_pt,
    ppt_pt_out_if.source        o_pt,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data
);

    logic [63:0] r_x_gains;
    logic [63:0] r_y_gains;
    logic [63:0] r_w_gains;
    logic [63:0] r_xy_offsets;
    logic [31:0] r_w_offset;
    logic [31:0] r_w_epsilon;

    logic                      r_rdy;
    logic [ppt_pkg::NSTG-1:0]  r_v;
    logic [ppt_pkg::NSTG-1:0]  r_lst;
    logic                      w_en;

    ppt_pkg::t_unp  r_cu [6];
    logic [31:0]    w_off [3];

    ppt_pkg::t_unp  r_ux;
    ppt_pkg::t_unp  r_uy;
    ppt_pkg::t_mulp r_mp [6];
    logic [31:0]    r_pf [6];
    ppt_pkg::t_alig r_a1 [3];
    ppt_pkg::t_sum  r_b1 [3];
    ppt_pkg::t_rnd  r_c1 [3];
    logic [31:0]    r_sf [3];
    ppt_pkg::t_alig r_a2 [3];
    ppt_pkg::t_sum  r_b2 [3];
    ppt_pkg::t_rnd  r_c2 [3];
    logic [31:0]    r_tf [3];
    ppt_pkg::t_div  r_dv [ppt_pkg::DIV_STEPS+1];
    ppt_pkg::t_side r_sd [ppt_pkg::SIDE_N];
    logic [31:0]    r_rf;
    ppt_pkg::t_unp  r_ux2;
    ppt_pkg::t_unp  r_uy2;
    ppt_pkg::t_unp  r_ur;
    ppt_pkg::t_side r_sd42;
    ppt_pkg::t_mulp r_mx;
    ppt_pkg::t_mulp r_my;
    logic           r_dg43;
    logic [31:0]    r_xo;
    logic [31:0]    r_yo;
    logic           r_dg;

    assign w_en       = !r_v[ppt_pkg::NSTG-1] || o_pt.ready;
    assign i_pt.ready = r_rdy && w_en;

    assign o_pt.valid        = r_v[ppt_pkg::NSTG-1];
    assign o_pt.x_out        = r_xo;
    assign o_pt.y_out        = r_yo;
    assign o_pt.w_degenerate = r_dg;
    assign o_pt.last_out     = r_lst[ppt_pkg::NSTG-1];

    assign w_off[0] = r_xy_offsets[31:0];
    assign w_off[1] = r_xy_offsets[63:32];
    assign w_off[2] = r_w_offset;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_gains    <= 64'h00000000_3F800000;
            r_y_gains    <= 64'h3F800000_00000000;
            r_w_gains    <= 64'd0;
            r_xy_offsets <= 64'd0;
            r_w_offset   <= 32'h3F800000;
            r_w_epsilon  <= 32'h358637BD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppt_pkg::CFG_X_GAINS:    r_x_gains    <= i_cfg_data;
                ppt_pkg::CFG_Y_GAINS:    r_y_gains    <= i_cfg_data;
                ppt_pkg::CFG_W_GAINS:    r_w_gains    <= i_cfg_data;
                ppt_pkg::CFG_XY_OFFSETS: r_xy_offsets <= i_cfg_data;
                ppt_pkg::CFG_W_OFFSET:   r_w_offset   <= i_cfg_data[31:0];
                ppt_pkg::CFG_W_EPSILON:  r_w_epsilon  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // gains unpacked once; products index k<3 take x, k>=3 take y
    always_ff @(posedge i_clk) begin
        r_cu[0] <= ppt_pkg::f_unpack(r_x_gains[31:0]);
        r_cu[1] <= ppt_pkg::f_unpack(r_y_gains[31:0]);
        r_cu[2] <= ppt_pkg::f_unpack(r_w_gains[31:0]);
        r_cu[3] <= ppt_pkg::f_unpack(r_x_gains[63:32]);
        r_cu[4] <= ppt_pkg::f_unpack(r_y_gains[63:32]);
        r_cu[5] <= ppt_pkg::f_unpack(r_w_gains[63:32]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
            r_v   <= '0;
        end else begin
            r_rdy <= 1'b1;
            if (w_en) begin
                r_v <= {r_v[ppt_pkg::NSTG-2:0], i_pt.valid && r_rdy};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lst <= {r_lst[ppt_pkg::NSTG-2:0], i_pt.last_in};

            r_ux <= ppt_pkg::f_unpack(i_pt.x_in);
            r_uy <= ppt_pkg::f_unpack(i_pt.y_in);

            for (int k = 0; k < 6; k++) begin
                r_mp[k] <= ppt_pkg::mul_a(r_cu[k], (k < 3) ? r_ux : r_uy);
                r_pf[k] <= ppt_pkg::round_pack(ppt_pkg::mul_b(r_mp[k]));
            end

            // lanes: X, Y, W
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= ppt_pkg::add_a(r_pf[k], r_pf[k+3]);
                r_b1[k] <= ppt_pkg::add_b(r_a1[k]);
                r_c1[k] <= ppt_pkg::add_c(r_b1[k]);
                r_sf[k] <= ppt_pkg::round_pack(r_c1[k]);
                r_a2[k] <= ppt_pkg::add_a(r_sf[k], w_off[k]);
                r_b2[k] <= ppt_pkg::add_b(r_a2[k]);
                r_c2[k] <= ppt_pkg::add_c(r_b2[k]);
                r_tf[k] <= ppt_pkg::round_pack(r_c2[k]);
            end

            // 1/W, one quotient bit per stage
            r_dv[0] <= ppt_pkg::div_init(r_tf[2]);
            for (int k = 1; k <= ppt_pkg::DIV_STEPS; k++) begin
                r_dv[k] <= ppt_pkg::div_step(r_dv[k-1]);
            end
            r_rf <= ppt_pkg::round_pack(ppt_pkg::div_fin(r_dv[ppt_pkg::DIV_STEPS]));

            r_sd[0].degen <= ppt_pkg::is_degen(r_tf[2], r_w_epsilon);
            r_sd[0].fx    <= r_tf[0];
            r_sd[0].fy    <= r_tf[1];
            for (int k = 1; k < ppt_pkg::SIDE_N; k++) begin
                r_sd[k] <= r_sd[k-1];
            end

            r_ux2  <= ppt_pkg::f_unpack(r_sd[ppt_pkg::SIDE_N-1].fx);
            r_uy2  <= ppt_pkg::f_unpack(r_sd[ppt_pkg::SIDE_N-1].fy);
            r_ur   <= ppt_pkg::f_unpack(r_rf);
            r_sd42 <= r_sd[ppt_pkg::SIDE_N-1];

            r_mx   <= ppt_pkg::mul_a(r_ux2, r_ur);
            r_my   <= ppt_pkg::mul_a(r_uy2, r_ur);
            r_dg43 <= r_sd42.degen;

            r_dg <= r_dg43;
            r_xo <= r_dg43 ? ppt_pkg::QNAN
                           : ppt_pkg::canon(ppt_pkg::round_pack(ppt_pkg::mul_b(r_mx)));
            r_yo <= r_dg43 ? ppt_pkg::QNAN
                           : ppt_pkg::canon(ppt_pkg::round_pack(ppt_pkg::mul_b(r_my)));
        end
    end

endmodule
